// ----- design/tdms_pkg.sv -----
// shared types and constants for the tryptic digest mass stream block
// no dependencies

package tdms_pkg;

    localparam int CodeW   = 8;
    localparam int WeightW = 24;
    localparam int SumW    = 48;
    localparam int PosW    = 16;

    localparam logic [1:0] CMD_LOAD    = 2'd0;
    localparam logic [1:0] CMD_RESIDUE = 2'd1;
    localparam logic [1:0] CMD_END     = 2'd2;

    localparam logic [1:0] KIND_PEPTIDE  = 2'd0;
    localparam logic [1:0] KIND_SENTINEL = 2'd1;
    localparam logic [1:0] KIND_ERROR    = 2'd2;

    localparam logic [CodeW-1:0] CODE_K = 8'h4B;
    localparam logic [CodeW-1:0] CODE_R = 8'h52;
    localparam logic [CodeW-1:0] CODE_P = 8'h50;

    localparam logic [SumW-1:0] SUM_MAX = {SumW{1'b1}};

    typedef struct packed {
        logic [1:0]       cmd;
        logic [CodeW-1:0] code;
        logic             known;
    } item_t;

    typedef struct packed {
        logic [1:0]      kind;
        logic [PosW-1:0] start;
        logic [SumW-1:0] weight;
        logic            last;
    } result_t;

endpackage

// ----- design/tdms_ram.sv -----
// generic single write port, single read port ram with registered read
// no dependencies

module tdms_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- design/tdms_fetch.sv -----
// input stage: weight table, entry valid bits and the registered item
// depends on tdms_pkg and tdms_ram

module tdms_fetch
    import tdms_pkg::*;
#(
    parameter int TABLE_ENTRIES = 256
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               item_valid,
    output logic               item_ready,
    input  logic [1:0]         command,
    input  logic [CodeW-1:0]   residue_code,
    input  logic [WeightW-1:0] residue_weight,
    input  logic               advance,
    output logic               stage_valid,
    output item_t              stage_item,
    output logic [WeightW-1:0] stage_weight
);

    localparam int IdxW = $clog2(TABLE_ENTRIES);

    logic                     accept;
    logic                     code_ok;
    logic [IdxW-1:0]          idx;
    logic                     load_we;
    logic [TABLE_ENTRIES-1:0] valid_reg;
    logic [TABLE_ENTRIES-1:0] valid_next;
    logic                     stage_valid_reg;
    logic                     stage_valid_next;
    item_t                    stage_item_reg;

    assign item_ready = !stage_valid_reg || advance;
    assign accept     = item_valid && item_ready;
    assign code_ok    = {1'b0, residue_code} < (CodeW+1)'(TABLE_ENTRIES);
    assign idx        = residue_code[IdxW-1:0];
    assign load_we    = accept && (command == CMD_LOAD) && code_ok;

    always_comb
    begin
        valid_next = valid_reg;
        if (load_we)
        begin
            valid_next[idx] = 1'b1;
        end
        stage_valid_next = accept ? 1'b1 : (advance ? 1'b0 : stage_valid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg       <= '0;
            stage_valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg       <= valid_next;
            stage_valid_reg <= stage_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            stage_item_reg.cmd   <= command;
            stage_item_reg.code  <= residue_code;
            stage_item_reg.known <= code_ok && valid_reg[idx];
        end
    end

    tdms_ram #(
        .WIDTH (WeightW),
        .DEPTH (TABLE_ENTRIES)
    ) u_table (
        .clk   (clk),
        .we    (load_we),
        .waddr (idx),
        .wdata (residue_weight),
        .re    (accept),
        .raddr (idx),
        .rdata (stage_weight)
    );

    assign stage_valid = stage_valid_reg;
    assign stage_item  = stage_item_reg;

endmodule

// ----- design/tdms_cleave.sv -----
// cut site detection, mass accumulation and result generation
// depends on tdms_pkg

module tdms_cleave
    import tdms_pkg::*;
#(
    parameter longint unsigned MAX_SEQUENCE_LENGTH = 65536
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               stage_valid,
    input  item_t              stage_item,
    input  logic [WeightW-1:0] stage_weight,
    input  logic               space_ok,
    output logic               advance,
    output logic [1:0]         push_count,
    output result_t            res0,
    output result_t            res1
);

    localparam logic [PosW-1:0] LenCap = (MAX_SEQUENCE_LENGTH - 1 < 65535) ?
                                         PosW'(MAX_SEQUENCE_LENGTH - 1) : {PosW{1'b1}};

    logic [PosW-1:0] pos_reg, pos_next;
    logic [PosW-1:0] start_reg, start_next;
    logic [SumW-1:0] sum_reg, sum_next;
    logic            cut_reg, cut_next;
    logic            abort_reg, abort_next;
    logic            cut;
    logic [SumW-1:0] base;
    logic [SumW:0]   added;

    assign advance = stage_valid && space_ok;
    assign cut     = cut_reg && (stage_item.code != CODE_P);
    assign base    = cut ? '0 : sum_reg;
    assign added   = {1'b0, base} + {{(SumW+1-WeightW){1'b0}}, stage_weight};

    always_comb
    begin
        pos_next   = pos_reg;
        start_next = start_reg;
        sum_next   = sum_reg;
        cut_next   = cut_reg;
        abort_next = abort_reg;
        push_count = 2'd0;
        res0       = '{kind: KIND_PEPTIDE, start: start_reg, weight: sum_reg, last: 1'b1};
        res1       = '{kind: KIND_SENTINEL, start: pos_reg, weight: '0, last: 1'b1};
        if (advance)
        begin
            case (stage_item.cmd)
                CMD_RESIDUE:
                begin
                    if (!abort_reg)
                    begin
                        if ((pos_reg >= LenCap) || !stage_item.known)
                        begin
                            res0       = '{kind: KIND_ERROR, start: pos_reg,
                                           weight: '0, last: 1'b1};
                            push_count = 2'd1;
                            abort_next = 1'b1;
                        end
                        else
                        begin
                            if (cut)
                            begin
                                push_count = 2'd1;
                                start_next = pos_reg;
                            end
                            sum_next = added[SumW] ? SUM_MAX : added[SumW-1:0];
                            cut_next = (stage_item.code == CODE_K) ||
                                       (stage_item.code == CODE_R);
                            pos_next = pos_reg + 1'b1;
                        end
                    end
                end
                CMD_END:
                begin
                    if (!abort_reg)
                    begin
                        res0.last  = 1'b0;
                        push_count = 2'd2;
                    end
                    pos_next   = '0;
                    start_next = '0;
                    sum_next   = '0;
                    cut_next   = 1'b0;
                    abort_next = 1'b0;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg   <= '0;
            start_reg <= '0;
            sum_reg   <= '0;
            cut_reg   <= 1'b0;
            abort_reg <= 1'b0;
        end
        else
        begin
            pos_reg   <= pos_next;
            start_reg <= start_next;
            sum_reg   <= sum_next;
            cut_reg   <= cut_next;
            abort_reg <= abort_next;
        end
    end

endmodule

// ----- design/tdms_outq.sv -----
// four entry result queue, takes up to two results per cycle
// depends on tdms_pkg

module tdms_outq
    import tdms_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic [1:0] push_count,
    input  result_t  res0,
    input  result_t  res1,
    output logic     space_ok,
    output logic     result_valid,
    input  logic     result_ready,
    output result_t  head
);

    localparam int Depth = 4;
    localparam int PtrW  = $clog2(Depth);

    result_t         entry_reg [Depth];
    logic [PtrW-1:0] wr_reg, wr_next;
    logic [PtrW-1:0] rd_reg, rd_next;
    logic [PtrW:0]   count_reg, count_next;
    logic            pop;

    assign result_valid = count_reg != '0;
    assign pop          = result_valid && result_ready;
    assign space_ok     = (count_reg <= (PtrW+1)'(Depth - 2)) ||
                          ((count_reg == (PtrW+1)'(Depth - 1)) && pop);
    assign head         = entry_reg[rd_reg];

    always_comb
    begin
        wr_next    = wr_reg + PtrW'(push_count);
        rd_next    = rd_reg + PtrW'(pop);
        count_next = count_reg + (PtrW+1)'(push_count) - (PtrW+1)'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg    <= '0;
            rd_reg    <= '0;
            count_reg <= '0;
        end
        else
        begin
            wr_reg    <= wr_next;
            rd_reg    <= rd_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_count != 2'd0)
        begin
            entry_reg[wr_reg] <= res0;
        end
        if (push_count == 2'd2)
        begin
            entry_reg[wr_reg + 1'b1] <= res1;
        end
    end

endmodule

// ----- design/tryptic_digest_mass_stream_core.sv -----
// top level of the tryptic digest mass stream block
// depends on tdms_pkg, tdms_fetch, tdms_cleave and tdms_outq

// Takes one beat per cycle: table loads, residues and end marks. A beat's
// table lookup is registered together with the beat; its results are then
// registered into the result queue, whose head drives the outputs.
// Each beat yields at most one result beat, except an end mark, which yields
// a peptide and a sentinel. A four entry result queue absorbs the extra beat.
// The input stalls only when result beats pile up faster than the output side
// takes them, as with end marks on back to back cycles or a stalled receiver.
// The weight table read port is the single lookup per residue.
module tryptic_digest_mass_stream_core
    import tdms_pkg::*;
#(
    parameter longint unsigned MAX_SEQUENCE_LENGTH = 65536,
    parameter int              TABLE_ENTRIES       = 256
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               item_valid,
    output logic               item_ready,
    input  logic [1:0]         command,
    input  logic [CodeW-1:0]   residue_code,
    input  logic [WeightW-1:0] residue_weight,
    output logic               result_valid,
    input  logic               result_ready,
    output logic [1:0]         kind,
    output logic [PosW-1:0]    start_position,
    output logic [SumW-1:0]    peptide_mass,
    output logic               last
);

    logic               advance;
    logic               stage_valid;
    item_t              stage_item;
    logic [WeightW-1:0] stage_weight;
    logic               space_ok;
    logic [1:0]         push_count;
    result_t            res0;
    result_t            res1;
    result_t            head;

    tdms_fetch #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_fetch (
        .clk            (clk),
        .rst_n          (rst_n),
        .item_valid     (item_valid),
        .item_ready     (item_ready),
        .command        (command),
        .residue_code   (residue_code),
        .residue_weight (residue_weight),
        .advance        (advance),
        .stage_valid    (stage_valid),
        .stage_item     (stage_item),
        .stage_weight   (stage_weight)
    );

    tdms_cleave #(
        .MAX_SEQUENCE_LENGTH (MAX_SEQUENCE_LENGTH)
    ) u_cleave (
        .clk          (clk),
        .rst_n        (rst_n),
        .stage_valid  (stage_valid),
        .stage_item   (stage_item),
        .stage_weight (stage_weight),
        .space_ok     (space_ok),
        .advance      (advance),
        .push_count   (push_count),
        .res0         (res0),
        .res1         (res1)
    );

    tdms_outq u_outq (
        .clk          (clk),
        .rst_n        (rst_n),
        .push_count   (push_count),
        .res0         (res0),
        .res1         (res1),
        .space_ok     (space_ok),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .head         (head)
    );

    assign kind           = head.kind;
    assign start_position = head.start;
    assign peptide_mass   = head.weight;
    assign last           = head.last;

endmodule

// ----- bench/tdms_digest_checker.sv -----
// checker for the tryptic digest mass stream block: predicts and compares result beats
// depends on tdms_pkg

module tdms_digest_checker
    import tdms_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               item_valid,
    input  logic               item_ready,
    input  logic [1:0]         command,
    input  logic [CodeW-1:0]   residue_code,
    input  logic [WeightW-1:0] residue_weight,
    input  logic               result_valid,
    input  logic               result_ready,
    input  logic [1:0]         kind,
    input  logic [PosW-1:0]    start_position,
    input  logic [SumW-1:0]    peptide_mass,
    input  logic               last,
    output int                 mismatch_count,
    output int                 pending_count,
    output int                 peptide_count,
    output int                 sentinel_count,
    output int                 error_count
);

    localparam logic [PosW-1:0] LEN_LIMIT = {PosW{1'b1}};

    logic [WeightW-1:0] mass_table [256];
    logic               mass_known [256];
    logic [PosW-1:0]    pos_count;
    logic [PosW-1:0]    pep_start;
    logic [SumW-1:0]    mass_sum;
    logic               cut_pending;
    logic               aborted;
    result_t            due_fragments [$];
    int                 fails;
    int                 n_pep;
    int                 n_sent;
    int                 n_err;

    function automatic result_t fragment(input logic [1:0] k, input logic [PosW-1:0] s,
                                         input logic [SumW-1:0] w, input logic l);
        result_t r;
        r.kind   = k;
        r.start  = s;
        r.weight = w;
        r.last   = l;
        return r;
    endfunction

    task automatic clear_digest();
        pos_count   = '0;
        pep_start   = '0;
        mass_sum    = '0;
        cut_pending = 1'b0;
        aborted     = 1'b0;
    endtask

    task automatic digest_beat(input logic [1:0] cmd, input logic [CodeW-1:0] code,
                               input logic [WeightW-1:0] weight);
        logic [SumW:0] wide;
        case (cmd)
            CMD_LOAD:
            begin
                mass_table[code] = weight;
                mass_known[code] = 1'b1;
            end
            CMD_RESIDUE:
            begin
                if (!aborted)
                begin
                    if (pos_count >= LEN_LIMIT || !mass_known[code])
                    begin
                        due_fragments.push_back(fragment(KIND_ERROR, pos_count, '0, 1'b1));
                        aborted = 1'b1;
                    end
                    else
                    begin
                        // a cut after k or r, unless proline follows
                        if (cut_pending && code != CODE_P)
                        begin
                            due_fragments.push_back(fragment(KIND_PEPTIDE, pep_start, mass_sum,
                                                             1'b1));
                            pep_start = pos_count;
                            mass_sum  = '0;
                        end
                        wide        = {1'b0, mass_sum} + (SumW+1)'(mass_table[code]);
                        mass_sum    = wide[SumW] ? SUM_MAX : wide[SumW-1:0];
                        cut_pending = (code == CODE_K || code == CODE_R);
                        pos_count   = pos_count + 1'b1;
                    end
                end
            end
            CMD_END:
            begin
                if (!aborted)
                begin
                    due_fragments.push_back(fragment(KIND_PEPTIDE, pep_start, mass_sum, 1'b0));
                    due_fragments.push_back(fragment(KIND_SENTINEL, pos_count, '0, 1'b1));
                end
                clear_digest();
            end
            default:
            begin
            end
        endcase
    endtask

    task automatic compare_field(input string name, input logic [SumW-1:0] want,
                                 input logic [SumW-1:0] got);
        if (want !== got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fails++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        result_t want;
        if (!rst_n)
        begin
            for (int i = 0; i < 256; i++)
            begin
                mass_table[i] = '0;
                mass_known[i] = 1'b0;
            end
            clear_digest();
            due_fragments.delete();
            fails  = 0;
            n_pep  = 0;
            n_sent = 0;
            n_err  = 0;
            mismatch_count <= 0;
            pending_count  <= 0;
            peptide_count  <= 0;
            sentinel_count <= 0;
            error_count    <= 0;
        end
        else
        begin
            if (result_valid && result_ready)
            begin
                if (due_fragments.size() == 0)
                begin
                    $error("result beat with nothing due: kind %0d, start_position %0d",
                           kind, start_position);
                    fails++;
                end
                else
                begin
                    want = due_fragments.pop_front();
                    compare_field("kind", SumW'(want.kind), SumW'(kind));
                    compare_field("start_position", SumW'(want.start), SumW'(start_position));
                    compare_field("peptide_mass", want.weight, peptide_mass);
                    compare_field("last", SumW'(want.last), SumW'(last));
                    case (want.kind)
                        KIND_PEPTIDE:  n_pep++;
                        KIND_SENTINEL: n_sent++;
                        default:       n_err++;
                    endcase
                end
            end
            if (item_valid && item_ready)
                digest_beat(command, residue_code, residue_weight);
            mismatch_count <= fails;
            pending_count  <= due_fragments.size();
            peptide_count  <= n_pep;
            sentinel_count <= n_sent;
            error_count    <= n_err;
        end
    end

endmodule

// ----- bench/tryptic_digest_mass_stream_core_test.sv -----
// testbench top for the tryptic digest mass stream block: clock, reset, beats and verdict
// depends on tdms_pkg, tryptic_digest_mass_stream_core and tdms_digest_checker

module tryptic_digest_mass_stream_core_test;
    import tdms_pkg::*;

    localparam logic [1:0] CMD_UNUSED = 2'd3;
    localparam int         IDLE_LIMIT = 2000;
    localparam int         RANDOM_BEATS = 1750;

    logic               clk = 1'b0;
    logic               rst_n;
    logic               item_valid;
    logic               item_ready;
    logic [1:0]         command;
    logic [CodeW-1:0]   residue_code;
    logic [WeightW-1:0] residue_weight;
    logic               result_valid;
    logic               result_ready = 1'b0;
    logic [1:0]         kind;
    logic [PosW-1:0]    start_position;
    logic [SumW-1:0]    peptide_mass;
    logic               last;

    int mismatch_count;
    int pending_count;
    int peptide_count;
    int sentinel_count;
    int error_count;

    string amino_letters = "ACDEFGHIKLMNPQRSTVWY";
    int    burst_left = 0;
    int    live_beats = 0;
    int    idle_cycles = 0;
    int    stall_mode = 0;
    int    stall_left = 0;
    int    ready_phase = 0;

    tryptic_digest_mass_stream_core u_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .item_valid     (item_valid),
        .item_ready     (item_ready),
        .command        (command),
        .residue_code   (residue_code),
        .residue_weight (residue_weight),
        .result_valid   (result_valid),
        .result_ready   (result_ready),
        .kind           (kind),
        .start_position (start_position),
        .peptide_mass   (peptide_mass),
        .last           (last)
    );

    tdms_digest_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .item_valid     (item_valid),
        .item_ready     (item_ready),
        .command        (command),
        .residue_code   (residue_code),
        .residue_weight (residue_weight),
        .result_valid   (result_valid),
        .result_ready   (result_ready),
        .kind           (kind),
        .start_position (start_position),
        .peptide_mass   (peptide_mass),
        .last           (last),
        .mismatch_count (mismatch_count),
        .pending_count  (pending_count),
        .peptide_count  (peptide_count),
        .sentinel_count (sentinel_count),
        .error_count    (error_count)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // receiver stalls: modes change whenever a random countdown runs out
    always @(posedge clk)
    begin
        ready_phase <= ready_phase + 1;
        if (stall_left == 0)
        begin
            stall_mode <= $urandom_range(0, 3);
            stall_left <= $urandom_range(32, 400);
        end
        else
            stall_left <= stall_left - 1;
        case (stall_mode)
            0:       result_ready <= 1'b1;
            1:       result_ready <= 1'($urandom_range(0, 1));
            2:       result_ready <= ($urandom_range(0, 3) == 0);
            default: result_ready <= (ready_phase % 8 < 5);
        endcase
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((item_valid && item_ready) || (result_valid && result_ready))
                idle_cycles <= 0;
            else if (idle_cycles + 1 >= IDLE_LIMIT)
            begin
                $display("timeout: no beat moved for %0d cycles", IDLE_LIMIT);
                $display("tryptic_digest_mass_stream_core_test NOT OK");
                $finish;
            end
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic offer_beat(input logic [1:0] cmd, input logic [CodeW-1:0] code,
                              input logic [WeightW-1:0] weight);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 24);
            if (gap > 0)
            begin
                item_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                     : $urandom_range(1, 24);
        end
        item_valid     <= 1'b1;
        command        <= cmd;
        residue_code   <= code;
        residue_weight <= weight;
        @(posedge clk);
        while (!item_ready) @(posedge clk);
        if (burst_left > 0)
            burst_left--;
        if (cmd != CMD_UNUSED)
            live_beats++;
    endtask

    function automatic logic [WeightW-1:0] pick_weight();
        int roll;
        roll = $urandom_range(0, 9);
        if (roll == 0)
            return '0;
        if (roll == 1)
            return {WeightW{1'b1}};
        return WeightW'($urandom_range(0, 24'hFFFFFF));
    endfunction

    function automatic logic [CodeW-1:0] pick_load_code();
        if ($urandom_range(0, 1) == 0)
            return amino_letters[$urandom_range(0, 19)];
        return CodeW'($urandom_range(0, 255));
    endfunction

    function automatic logic [CodeW-1:0] pick_residue();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 14)
            return CODE_K;
        if (roll < 28)
            return CODE_R;
        if (roll < 38)
            return CODE_P;
        if (roll < 90)
            return amino_letters[$urandom_range(0, 19)];
        if (roll < 95)
            return CodeW'($urandom_range(0, 255));
        // lower case letters are mostly not in the table
        return CodeW'($urandom_range(97, 122));
    endfunction

    initial
    begin
        int seq_len;
        int roll;
        int first_live;
        rst_n          = 1'b0;
        item_valid     = 1'b0;
        command        = CMD_LOAD;
        residue_code   = '0;
        residue_weight = '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty sequence, then a residue with no table entry, then a beat after the abort
        offer_beat(CMD_END, 8'h00, 24'h000000);
        offer_beat(CMD_RESIDUE, "A", 24'hFFFFFF);
        offer_beat(CMD_RESIDUE, "A", 24'h000000);
        offer_beat(CMD_END, 8'hFF, 24'hFFFFFF);

        offer_beat(CMD_LOAD, "A", 24'h000000);
        offer_beat(CMD_LOAD, CODE_K, 24'hFFFFFF);
        offer_beat(CMD_LOAD, CODE_R, pick_weight());
        offer_beat(CMD_LOAD, CODE_P, pick_weight());
        offer_beat(CMD_LOAD, "G", 24'h000001);
        offer_beat(CMD_LOAD, 8'h00, pick_weight());
        offer_beat(CMD_LOAD, 8'hFF, pick_weight());

        // proline blocks a cut, double arginine, no cut after the final lysine
        offer_beat(CMD_RESIDUE, 8'hFF, 24'h000000);
        offer_beat(CMD_RESIDUE, "A", 24'hFFFFFF);
        offer_beat(CMD_RESIDUE, CODE_K, 24'h000000);
        offer_beat(CMD_RESIDUE, CODE_P, 24'h000000);
        offer_beat(CMD_RESIDUE, CODE_R, 24'h000000);
        offer_beat(CMD_RESIDUE, CODE_R, 24'h000000);
        offer_beat(CMD_RESIDUE, "G", 24'h000000);
        offer_beat(CMD_RESIDUE, 8'h00, 24'h000000);
        offer_beat(CMD_RESIDUE, CODE_K, 24'h000000);
        offer_beat(CMD_END, 8'h00, 24'h000000);
        offer_beat(CMD_UNUSED, 8'hFF, 24'hFFFFFF);

        // load in mid sequence, then an unknown residue where a cut was due
        offer_beat(CMD_RESIDUE, "G", 24'h000000);
        offer_beat(CMD_LOAD, "G", 24'h800000);
        offer_beat(CMD_RESIDUE, CODE_K, 24'h000000);
        offer_beat(CMD_RESIDUE, "G", 24'h000000);
        offer_beat(CMD_RESIDUE, CODE_R, 24'h000000);
        offer_beat(CMD_RESIDUE, "k", 24'h000000);
        offer_beat(CMD_END, 8'h00, 24'h000000);

        first_live = live_beats;
        for (int i = 0; i < 20; i++)
            offer_beat(CMD_LOAD, amino_letters[i], pick_weight());
        while (live_beats - first_live < RANDOM_BEATS)
        begin
            seq_len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 80)
                                                  : $urandom_range(0, 12);
            for (int i = 0; i < seq_len; i++)
            begin
                roll = $urandom_range(0, 99);
                if (roll < 3)
                    offer_beat(CMD_LOAD, pick_load_code(), pick_weight());
                else if (roll < 5)
                    offer_beat(CMD_UNUSED, CodeW'($urandom_range(0, 255)), pick_weight());
                else
                    offer_beat(CMD_RESIDUE, pick_residue(), pick_weight());
            end
            if ($urandom_range(0, 19) != 0)
                offer_beat(CMD_END, CodeW'($urandom_range(0, 255)), pick_weight());
            if ($urandom_range(0, 7) == 0)
                offer_beat(CMD_LOAD, pick_load_code(), pick_weight());
        end

        item_valid <= 1'b0;
        repeat (2) @(posedge clk);
        while (pending_count != 0) @(posedge clk);
        repeat (16) @(posedge clk);

        $display("sent %0d beats: directed corner cases, random sequences with mid run loads",
                 live_beats);
        $display("checked %0d peptides, %0d sentinels, %0d unknown residue errors",
                 peptide_count, sentinel_count, error_count);
        if (mismatch_count == 0 && pending_count == 0)
            $display("tryptic_digest_mass_stream_core_test OK");
        else
            $display("tryptic_digest_mass_stream_core_test NOT OK");
        $finish;
    end

endmodule

// ----- files.f -----
design/tdms_pkg.sv
design/tdms_ram.sv
design/tdms_fetch.sv
design/tdms_cleave.sv
design/tdms_outq.sv
design/tryptic_digest_mass_stream_core.sv
bench/tdms_digest_checker.sv
bench/tryptic_digest_mass_stream_core_test.sv
